### rtl/core/bsmc_pkg.sv
// Shared types, codes and constants of the brew scale mode controller.
package bsmc_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int CSR_ADDR_BITS     = 4;
   localparam int CSR_DATA_BITS     = 32;
   localparam int REQ_DATA_BITS     = 64;
   localparam int REQ_USER_BITS     = 2;
   localparam int RSP_DATA_BITS     = 8;

   localparam int WEIGHT_BITS  = 20;
   localparam int TARGET_BITS  = 18;
   localparam int STIME_BITS   = 16;
   localparam int EPS_BITS     = 10;
   localparam int STAMP_BITS   = 32;

   localparam logic [TARGET_BITS-1:0] TARGET_RESET = 18'd1800;
   localparam logic [STIME_BITS-1:0]  STIME_RESET  = 16'd2000;
   localparam logic [EPS_BITS-1:0]    EPS_RESET    = 10'd30;

   localparam logic [1:0] REG_TARGET_WEIGHT  = 2'd0;
   localparam logic [1:0] REG_STABLE_TIME_MS = 2'd1;
   localparam logic [1:0] REG_STABLE_EPSILON = 2'd2;

   localparam logic [1:0] OP_EVENT  = 2'd0;
   localparam logic [1:0] OP_MODE   = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;

   localparam logic [2:0] EV_ESTOP  = 3'd0;
   localparam logic [2:0] EV_ERROR  = 3'd1;
   localparam logic [2:0] EV_CUP    = 3'd2;
   localparam logic [2:0] EV_START  = 3'd3;
   localparam logic [2:0] EV_STOP   = 3'd4;
   localparam logic [2:0] EV_TARGET = 3'd5;
   localparam logic [2:0] EV_MOVED  = 3'd6;
   localparam logic [2:0] EV_STABLE = 3'd7;

   localparam logic MODE_MILL = 1'b0;
   localparam logic MODE_BREW = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_GRINDING  = 3'd1,
      ST_ESP_IDLE  = 3'd2,
      ST_PULL_SHOT = 3'd3,
      ST_PULLING   = 3'd4,
      ST_COMPLETE  = 3'd5,
      ST_ERROR     = 3'd6
   } state_type;

   typedef struct packed {
      logic [TARGET_BITS-1:0] target_weight;
      logic [STIME_BITS-1:0]  stable_time_ms;
      logic [EPS_BITS-1:0]    stable_epsilon;
   } cfg_type;

   typedef struct packed {
      logic [1:0]             op;
      logic [2:0]             event_code;
      logic                   mode_req;
      logic [WEIGHT_BITS-1:0] weight_now;
      logic [STAMP_BITS-1:0]  time_now_ms;
      logic                   motor_timed_out;
      logic                   motor_is_running;
   } item_type;

   typedef struct packed {
      state_type              machine_state;
      logic                   machine_mode;
      logic [WEIGHT_BITS-1:0] session_start_weight;
      logic                   tracking_armed;
      logic [WEIGHT_BITS-1:0] reference_weight;
      logic                   error_latched;
      logic                   motor_seen_running;
   } ctl_type;

   typedef struct packed {
      logic      error_flag;
      logic      motor_on;
      logic      motor_stop;
      logic      motor_start;
      logic      mode_now;
      logic [2:0] state_now;
   } rsp_type;

   typedef struct packed {
      logic      take;
      state_type nxt;
   } ev_result_type;

endpackage

### rtl/core/brew_scale_mode_controller_unit.sv
// Top level of the brew scale mode controller: stream channels, state and result registers.
//
// Items arrive on the req_ stream: tuser carries the item kind (event, mode
// request, periodic update), tdata the event code, requested mode, weight,
// millisecond timestamp and motor status. Every item gives exactly one result
// on the rsp_ stream with state, mode, motor start/stop pulses, the motor
// running flag and the sticky error flag. Target weight, stable time and
// stable epsilon are set through the csr_ APB port; the user writes them only
// while idle, which the block itself does not enforce. An accepted item sits
// in the input register, where the single pass of next-state logic runs; the
// result register loads when the item advances, and the result leaves from it.
// One item per cycle is sustained while the receiver takes the results.
// When the receiver stalls, the result register holds and the input register
// takes one more item; req_tready then drops until the result is taken.
// Reset clears both channels, restores the register defaults and puts the
// controller in idle, grinder mode, with the error flag clear.
module brew_scale_mode_controller_unit #(
   parameter int TIME_BITS = bsmc_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [2:0] event_code, [3] mode_req, [23:4] weight_now, [55:24] time_now_ms,
   // [56] motor_timed_out, [57] motor_is_running, [63:58] zero
   input  logic [bsmc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [1:0] op
   input  logic [bsmc_pkg::REQ_USER_BITS-1:0]  req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] state_now, [3] mode_now, [4] motor_start, [5] motor_stop,
   // [6] motor_on, [7] error_flag
   output logic [bsmc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bsmc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bsmc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bsmc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   bsmc_pkg::cfg_type    cfg;
   bsmc_pkg::item_type   item_ff, item_in;
   logic                 in_valid_ff, in_valid_in;
   logic                 out_valid_ff, out_valid_in;
   bsmc_pkg::rsp_type    out_ff, out_in;
   bsmc_pkg::ctl_type    ctl_ff, ctl_in;
   logic [TIME_BITS-1:0] steady_ff, steady_in;
   bsmc_pkg::ctl_type    ctl_next;
   logic [TIME_BITS-1:0] steady_next;
   bsmc_pkg::rsp_type    rsp_next;
   logic                 advance;
   logic                 take_req;

   bsmc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bsmc_step #(.TIME_BITS(TIME_BITS)) u_step (
      .item         (item_ff),
      .cfg          (cfg),
      .ctl          (ctl_ff),
      .steady_since (steady_ff),
      .ctl_next     (ctl_next),
      .steady_next  (steady_next),
      .rsp          (rsp_next)
   );

   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign take_req   = req_tvalid & req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      item_in                  = item_ff;
      in_valid_in              = in_valid_ff & ~advance;
      out_valid_in             = out_valid_ff & ~rsp_tready;
      out_in                   = out_ff;
      ctl_in                   = ctl_ff;
      steady_in                = steady_ff;
      if (take_req) begin
         in_valid_in              = 1'b1;
         item_in.op               = req_tuser;
         item_in.event_code       = req_tdata[2:0];
         item_in.mode_req         = req_tdata[3];
         item_in.weight_now       = req_tdata[23:4];
         item_in.time_now_ms      = req_tdata[55:24];
         item_in.motor_timed_out  = req_tdata[56];
         item_in.motor_is_running = req_tdata[57];
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = rsp_next;
         ctl_in       = ctl_next;
         steady_in    = steady_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctl_ff.machine_state        <= bsmc_pkg::ST_IDLE;
         ctl_ff.machine_mode         <= bsmc_pkg::MODE_MILL;
         ctl_ff.session_start_weight <= '0;
         ctl_ff.tracking_armed       <= 1'b0;
         ctl_ff.reference_weight     <= '0;
         ctl_ff.error_latched        <= 1'b0;
         ctl_ff.motor_seen_running   <= 1'b0;
         steady_ff                   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ctl_ff       <= ctl_in;
         steady_ff    <= steady_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

endmodule

### rtl/core/bsmc_csr.sv
// APB register bank for target weight, stable time and stable epsilon.
module bsmc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bsmc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bsmc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bsmc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output bsmc_pkg::cfg_type                   cfg
);

   bsmc_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            bsmc_pkg::REG_TARGET_WEIGHT:
               cfg_in.target_weight  = csr_pwdata[bsmc_pkg::TARGET_BITS-1:0];
            bsmc_pkg::REG_STABLE_TIME_MS:
               cfg_in.stable_time_ms = csr_pwdata[bsmc_pkg::STIME_BITS-1:0];
            bsmc_pkg::REG_STABLE_EPSILON:
               cfg_in.stable_epsilon = csr_pwdata[bsmc_pkg::EPS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         bsmc_pkg::REG_TARGET_WEIGHT:
            csr_prdata = {14'd0, cfg_ff.target_weight};
         bsmc_pkg::REG_STABLE_TIME_MS:
            csr_prdata = {16'd0, cfg_ff.stable_time_ms};
         bsmc_pkg::REG_STABLE_EPSILON:
            csr_prdata = {22'd0, cfg_ff.stable_epsilon};
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_weight  <= bsmc_pkg::TARGET_RESET;
         cfg_ff.stable_time_ms <= bsmc_pkg::STIME_RESET;
         cfg_ff.stable_epsilon <= bsmc_pkg::EPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/bsmc_step.sv
// Next-state and result logic for one item of the scale controller.
module bsmc_step #(
   parameter int TIME_BITS = bsmc_pkg::TIME_BITS_DEFAULT
) (
   input  bsmc_pkg::item_type    item,
   input  bsmc_pkg::cfg_type     cfg,
   input  bsmc_pkg::ctl_type     ctl,
   input  logic [TIME_BITS-1:0]  steady_since,
   output bsmc_pkg::ctl_type     ctl_next,
   output logic [TIME_BITS-1:0]  steady_next,
   output bsmc_pkg::rsp_type     rsp
);

   function automatic bsmc_pkg::ev_result_type ev_step(
      input bsmc_pkg::state_type st,
      input logic                mode,
      input logic [2:0]          ev
   );
      bsmc_pkg::ev_result_type r;
      r.take = 1'b0;
      r.nxt  = st;
      if (ev == bsmc_pkg::EV_ESTOP) begin
         r.take = 1'b1;
         r.nxt  = bsmc_pkg::ST_IDLE;
      end else if (ev == bsmc_pkg::EV_ERROR) begin
         r.take = 1'b1;
         r.nxt  = bsmc_pkg::ST_ERROR;
      end else if (mode == bsmc_pkg::MODE_MILL) begin
         case (st)
            bsmc_pkg::ST_IDLE: begin
               if (ev == bsmc_pkg::EV_CUP || ev == bsmc_pkg::EV_START) begin
                  r.take = 1'b1;
                  r.nxt  = bsmc_pkg::ST_GRINDING;
               end
            end
            bsmc_pkg::ST_GRINDING: begin
               if (ev == bsmc_pkg::EV_TARGET || ev == bsmc_pkg::EV_STOP) begin
                  r.take = 1'b1;
                  r.nxt  = bsmc_pkg::ST_IDLE;
               end
            end
            default: ;
         endcase
      end else begin
         case (st)
            bsmc_pkg::ST_ESP_IDLE: begin
               if (ev == bsmc_pkg::EV_START) begin
                  r.take = 1'b1;
                  r.nxt  = bsmc_pkg::ST_PULL_SHOT;
               end
            end
            bsmc_pkg::ST_PULL_SHOT: begin
               if (ev == bsmc_pkg::EV_MOVED) begin
                  r.take = 1'b1;
                  r.nxt  = bsmc_pkg::ST_PULLING;
               end else if (ev == bsmc_pkg::EV_STOP) begin
                  r.take = 1'b1;
                  r.nxt  = bsmc_pkg::ST_ESP_IDLE;
               end
            end
            bsmc_pkg::ST_PULLING: begin
               if (ev == bsmc_pkg::EV_STABLE) begin
                  r.take = 1'b1;
                  r.nxt  = bsmc_pkg::ST_COMPLETE;
               end else if (ev == bsmc_pkg::EV_STOP) begin
                  r.take = 1'b1;
                  r.nxt  = bsmc_pkg::ST_ESP_IDLE;
               end
            end
            bsmc_pkg::ST_COMPLETE: begin
               if (ev == bsmc_pkg::EV_STOP) begin
                  r.take = 1'b1;
                  r.nxt  = bsmc_pkg::ST_ESP_IDLE;
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   logic [TIME_BITS-1:0]    now_t;
   logic [TIME_BITS-1:0]    elapsed;
   logic signed [21:0]      gain;
   logic signed [20:0]      w_ext;
   logic signed [20:0]      eps_ext;
   logic [20:0]             ref_diff;
   logic [20:0]             ref_dist;
   logic                    was_motor;
   logic                    now_motor;
   bsmc_pkg::ev_result_type evr;

   assign now_t    = TIME_BITS'(item.time_now_ms);
   assign elapsed  = now_t - steady_since;
   assign gain     = $signed({{2{item.weight_now[19]}}, item.weight_now})
                   - $signed({{2{ctl.session_start_weight[19]}}, ctl.session_start_weight});
   assign w_ext    = $signed({item.weight_now[19], item.weight_now});
   assign eps_ext  = $signed({11'd0, cfg.stable_epsilon});
   assign ref_diff = {item.weight_now[19], item.weight_now}
                   - {ctl.reference_weight[19], ctl.reference_weight};
   assign ref_dist = ref_diff[20] ? (21'd0 - ref_diff) : ref_diff;

   always_comb begin
      ctl_next    = ctl;
      steady_next = steady_since;
      evr.take    = 1'b0;
      evr.nxt     = ctl.machine_state;
      case (item.op)
         bsmc_pkg::OP_EVENT: begin
            evr = ev_step(ctl.machine_state, ctl.machine_mode, item.event_code);
            if (evr.take && ctl.machine_state == bsmc_pkg::ST_IDLE &&
                evr.nxt == bsmc_pkg::ST_GRINDING) begin
               ctl_next.session_start_weight = item.weight_now;
            end
         end
         bsmc_pkg::OP_MODE: begin
            if (item.mode_req != ctl.machine_mode) begin
               if (ctl.machine_state == bsmc_pkg::ST_IDLE &&
                   item.mode_req == bsmc_pkg::MODE_BREW) begin
                  ctl_next.machine_mode = bsmc_pkg::MODE_BREW;
                  evr.take = 1'b1;
                  evr.nxt  = bsmc_pkg::ST_ESP_IDLE;
               end else if (ctl.machine_state == bsmc_pkg::ST_ESP_IDLE &&
                            item.mode_req == bsmc_pkg::MODE_MILL) begin
                  ctl_next.machine_mode = bsmc_pkg::MODE_MILL;
                  evr.take = 1'b1;
                  evr.nxt  = bsmc_pkg::ST_IDLE;
               end
            end
         end
         bsmc_pkg::OP_UPDATE: begin
            ctl_next.motor_seen_running = item.motor_is_running;
            if (item.motor_timed_out) begin
               ctl_next.error_latched = 1'b1;
               evr.take = 1'b1;
               evr.nxt  = bsmc_pkg::ST_ERROR;
            end else begin
               case (ctl.machine_state)
                  bsmc_pkg::ST_GRINDING: begin
                     if (gain >= $signed({4'd0, cfg.target_weight}))
                        evr = ev_step(ctl.machine_state, ctl.machine_mode,
                                      bsmc_pkg::EV_TARGET);
                  end
                  bsmc_pkg::ST_PULL_SHOT: begin
                     if (w_ext > eps_ext)
                        evr = ev_step(ctl.machine_state, ctl.machine_mode,
                                      bsmc_pkg::EV_MOVED);
                  end
                  bsmc_pkg::ST_PULLING: begin
                     if (!ctl.tracking_armed || ref_dist > {11'd0, cfg.stable_epsilon}) begin
                        ctl_next.tracking_armed   = 1'b1;
                        ctl_next.reference_weight = item.weight_now;
                        steady_next               = now_t;
                     end else if (elapsed >= TIME_BITS'(cfg.stable_time_ms)) begin
                        evr = ev_step(ctl.machine_state, ctl.machine_mode,
                                      bsmc_pkg::EV_STABLE);
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase

      was_motor = (ctl.machine_state == bsmc_pkg::ST_GRINDING) ||
                  (ctl.machine_state == bsmc_pkg::ST_PULL_SHOT);
      now_motor = (evr.nxt == bsmc_pkg::ST_GRINDING) ||
                  (evr.nxt == bsmc_pkg::ST_PULL_SHOT);
      rsp.motor_start = 1'b0;
      rsp.motor_stop  = 1'b0;
      if (evr.take) begin
         ctl_next.machine_state      = evr.nxt;
         ctl_next.motor_seen_running = item.motor_is_running;
         if (evr.nxt == bsmc_pkg::ST_PULLING)
            ctl_next.tracking_armed = 1'b0;
         rsp.motor_start = now_motor & ~was_motor;
         rsp.motor_stop  = was_motor & ~now_motor;
      end

      rsp.state_now     = ctl_next.machine_state;
      rsp.mode_now      = ctl_next.machine_mode;
      rsp.motor_on      = ctl_next.motor_seen_running;
      rsp.error_flag    = ctl_next.error_latched;
   end

endmodule

### rtl/core/bsmc_checker.sv
// Port-level checks of the brew scale mode controller, bound to the top level.
module bsmc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [bsmc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic                                csr_pready
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[4] && rsp_tdata[5]))
      else $error("motor start and stop in one result");

   // start pulse only when landing in grinding or pull shot
   a_start_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |->
         (rsp_tdata[2:0] == bsmc_pkg::ST_GRINDING) ||
         (rsp_tdata[2:0] == bsmc_pkg::ST_PULL_SHOT))
      else $error("motor start outside a motor state");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr pready low");

endmodule

bind brew_scale_mode_controller_unit bsmc_checker u_bsmc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

### tb/brew_scale_mode_controller_unit_tb.sv
// Brew scale mode controller testbench: directed table split around guided random traffic.
`timescale 1ns / 100ps
module brew_scale_mode_controller_unit_tb;

   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam int N_HEAD = 27;
   localparam int N_PLAN = 34;
   localparam int N_RAND = 530;

   typedef struct packed {
      logic [1:0]                       op;
      logic [2:0]                       ev;
      logic                             rq;
      logic [bsmc_pkg::WEIGHT_BITS-1:0] w;
      logic [bsmc_pkg::STAMP_BITS-1:0]  ms;
      logic                             tmo;
      logic                             run;
      logic                             chk;
      bsmc_pkg::rsp_type                want;
   } scale_item_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [bsmc_pkg::REQ_DATA_BITS-1:0]   req_tdata = '0;
   logic [bsmc_pkg::REQ_USER_BITS-1:0]   req_tuser = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [bsmc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata;
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [bsmc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr = '0;
   logic [bsmc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata = '0;
   logic [bsmc_pkg::CSR_DATA_BITS-1:0]   csr_prdata;
   logic                                 csr_pready;

   always #10 clock = ~clock;

   brew_scale_mode_controller_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // controller shadow
   logic [bsmc_pkg::TARGET_BITS-1:0]        cfg_target = bsmc_pkg::TARGET_RESET;
   logic [bsmc_pkg::STIME_BITS-1:0]         cfg_stime = bsmc_pkg::STIME_RESET;
   logic [bsmc_pkg::EPS_BITS-1:0]           cfg_eps = bsmc_pkg::EPS_RESET;
   bsmc_pkg::state_type                     mdl_state = bsmc_pkg::ST_IDLE;
   logic                                    mdl_mode = bsmc_pkg::MODE_MILL;
   logic signed [bsmc_pkg::WEIGHT_BITS-1:0] mdl_start_w = '0;
   logic signed [bsmc_pkg::WEIGHT_BITS-1:0] mdl_ref_w = '0;
   logic                                    mdl_armed = 1'b0;
   logic [bsmc_pkg::STAMP_BITS-1:0]         mdl_steady = '0;
   logic                                    mdl_err = 1'b0;
   logic                                    mdl_run_seen = 1'b0;
   logic                                    cur_run, pulse_on, pulse_off;

   bsmc_pkg::rsp_type                       status_q[$];
   bsmc_pkg::rsp_type                       typed_want = '0;
   logic                                    typed_on = 1'b0;
   int                                      fails = 0;
   int                                      send_idle = 0;
   int                                      recv_idle = 0;
   int                                      hold_ask = 0;
   int                                      hold_left = 0;
   logic                                    trap_ok = 1'b0;
   logic [bsmc_pkg::STAMP_BITS-1:0]         stamp_ms = 32'hFFF0_0000;

   scale_item_type plan [N_PLAN] = '{
      '{bsmc_pkg::OP_UPDATE, bsmc_pkg::EV_ESTOP, 1'b0, 20'd0, 32'd0, 1'b0, 1'b0, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b0, bsmc_pkg::MODE_MILL, bsmc_pkg::ST_IDLE}},
      '{OP_UNKNOWN, bsmc_pkg::EV_STABLE, 1'b1, 20'hFFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b0, bsmc_pkg::MODE_MILL, bsmc_pkg::ST_IDLE}},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_START, 1'b0, 20'h80000, 32'd0, 1'b0, 1'b1, 1'b1,
        '{1'b0, 1'b1, 1'b0, 1'b1, bsmc_pkg::MODE_MILL, bsmc_pkg::ST_GRINDING}},
      '{bsmc_pkg::OP_UPDATE, bsmc_pkg::EV_ESTOP, 1'b0, 20'h80707, 32'd100,
        1'b0, 1'b1, 1'b0, '0},
      '{bsmc_pkg::OP_UPDATE, bsmc_pkg::EV_ESTOP, 1'b0, 20'h7FFFF, 32'd200, 1'b0, 1'b0, 1'b1,
        '{1'b0, 1'b0, 1'b1, 1'b0, bsmc_pkg::MODE_MILL, bsmc_pkg::ST_IDLE}},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_CUP, 1'b0, 20'd100, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_MOVED, 1'b0, 20'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_STOP, 1'b0, 20'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_MODE, bsmc_pkg::EV_ESTOP, bsmc_pkg::MODE_MILL, 20'd0, 32'd0,
        1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_MODE, bsmc_pkg::EV_ESTOP, bsmc_pkg::MODE_BREW, 20'd0, 32'd0,
        1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_START, 1'b0, 20'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{bsmc_pkg::OP_MODE, bsmc_pkg::EV_ESTOP, bsmc_pkg::MODE_MILL, 20'd0, 32'd0,
        1'b0, 1'b1, 1'b0, '0},
      '{bsmc_pkg::OP_UPDATE, bsmc_pkg::EV_ESTOP, 1'b0, 20'd30, 32'd1000,
        1'b0, 1'b1, 1'b0, '0},
      '{bsmc_pkg::OP_UPDATE, bsmc_pkg::EV_ESTOP, 1'b0, 20'd31, 32'd1100,
        1'b0, 1'b1, 1'b0, '0},
      '{bsmc_pkg::OP_UPDATE, bsmc_pkg::EV_ESTOP, 1'b0, 20'd500, 32'hFFFF_F000,
        1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_UPDATE, bsmc_pkg::EV_ESTOP, 1'b0, 20'd530, 32'hFFFF_F7CF,
        1'b0, 1'b0, 1'b0, '0},
      // steady time reached across the timestamp wrap
      '{bsmc_pkg::OP_UPDATE, bsmc_pkg::EV_ESTOP, 1'b0, 20'd470, 32'h0000_0400,
        1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_STOP, 1'b0, 20'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_START, 1'b0, 20'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_MOVED, 1'b0, 20'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_STABLE, 1'b0, 20'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_STOP, 1'b0, 20'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_MODE, bsmc_pkg::EV_ESTOP, bsmc_pkg::MODE_MILL, 20'd0, 32'd0,
        1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_CUP, 1'b0, 20'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{bsmc_pkg::OP_UPDATE, bsmc_pkg::EV_ESTOP, 1'b0, 20'd0, 32'd0, 1'b1, 1'b1, 1'b1,
        '{1'b1, 1'b1, 1'b1, 1'b0, bsmc_pkg::MODE_MILL, bsmc_pkg::ST_ERROR}},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_ERROR, 1'b0, 20'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_ESTOP, 1'b0, 20'd0, 32'd0, 1'b0, 1'b0, 1'b1,
        '{1'b1, 1'b0, 1'b0, 1'b0, bsmc_pkg::MODE_MILL, bsmc_pkg::ST_IDLE}},
      // espresso mode survives an emergency stop and cannot be left again
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_ESTOP, 1'b0, 20'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_MODE, bsmc_pkg::EV_ESTOP, bsmc_pkg::MODE_BREW, 20'd0, 32'd0,
        1'b0, 1'b1, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_ESTOP, 1'b0, 20'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_MODE, bsmc_pkg::EV_ESTOP, bsmc_pkg::MODE_MILL, 20'd0, 32'd0,
        1'b0, 1'b1, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_START, 1'b0, 20'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{bsmc_pkg::OP_UPDATE, bsmc_pkg::EV_ESTOP, 1'b0, 20'd0, 32'd0, 1'b1, 1'b1, 1'b0, '0},
      '{bsmc_pkg::OP_EVENT, bsmc_pkg::EV_ESTOP, 1'b0, 20'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0}
   };

   function automatic bit is_motor(bsmc_pkg::state_type s);
      return s == bsmc_pkg::ST_GRINDING || s == bsmc_pkg::ST_PULL_SHOT;
   endfunction

   function automatic void enter_state(bsmc_pkg::state_type nxt);
      bit was, now_on;
      was = is_motor(mdl_state);
      now_on = is_motor(nxt);
      mdl_state = nxt;
      if (nxt == bsmc_pkg::ST_PULLING) mdl_armed = 1'b0;
      if (now_on && !was) pulse_on = 1'b1;
      else if (was && !now_on) pulse_off = 1'b1;
      mdl_run_seen = cur_run;
   endfunction

   function automatic void take_event(logic [2:0] ev,
                                      logic signed [bsmc_pkg::WEIGHT_BITS-1:0] w);
      if (ev == bsmc_pkg::EV_ESTOP) enter_state(bsmc_pkg::ST_IDLE);
      else if (ev == bsmc_pkg::EV_ERROR) enter_state(bsmc_pkg::ST_ERROR);
      else if (mdl_mode == bsmc_pkg::MODE_MILL) begin
         if (mdl_state == bsmc_pkg::ST_IDLE &&
             (ev == bsmc_pkg::EV_CUP || ev == bsmc_pkg::EV_START)) begin
            mdl_start_w = w;
            enter_state(bsmc_pkg::ST_GRINDING);
         end else if (mdl_state == bsmc_pkg::ST_GRINDING &&
                      (ev == bsmc_pkg::EV_TARGET || ev == bsmc_pkg::EV_STOP))
            enter_state(bsmc_pkg::ST_IDLE);
      end else begin
         case (mdl_state)
            bsmc_pkg::ST_ESP_IDLE:
               if (ev == bsmc_pkg::EV_START) enter_state(bsmc_pkg::ST_PULL_SHOT);
            bsmc_pkg::ST_PULL_SHOT: begin
               if (ev == bsmc_pkg::EV_MOVED) enter_state(bsmc_pkg::ST_PULLING);
               else if (ev == bsmc_pkg::EV_STOP) enter_state(bsmc_pkg::ST_ESP_IDLE);
            end
            bsmc_pkg::ST_PULLING: begin
               if (ev == bsmc_pkg::EV_STABLE) enter_state(bsmc_pkg::ST_COMPLETE);
               else if (ev == bsmc_pkg::EV_STOP) enter_state(bsmc_pkg::ST_ESP_IDLE);
            end
            bsmc_pkg::ST_COMPLETE:
               if (ev == bsmc_pkg::EV_STOP) enter_state(bsmc_pkg::ST_ESP_IDLE);
            default: ;
         endcase
      end
   endfunction

   function automatic bsmc_pkg::rsp_type predict_status(scale_item_type it);
      bsmc_pkg::rsp_type                       r;
      logic signed [bsmc_pkg::WEIGHT_BITS-1:0] w;
      int                                      gap;
      w = it.w;
      cur_run = it.run;
      pulse_on = 1'b0;
      pulse_off = 1'b0;
      case (it.op)
         bsmc_pkg::OP_EVENT: take_event(it.ev, w);
         bsmc_pkg::OP_MODE: begin
            if (it.rq != mdl_mode) begin
               if (mdl_state == bsmc_pkg::ST_IDLE && it.rq == bsmc_pkg::MODE_BREW) begin
                  mdl_mode = bsmc_pkg::MODE_BREW;
                  enter_state(bsmc_pkg::ST_ESP_IDLE);
               end else if (mdl_state == bsmc_pkg::ST_ESP_IDLE &&
                            it.rq == bsmc_pkg::MODE_MILL) begin
                  mdl_mode = bsmc_pkg::MODE_MILL;
                  enter_state(bsmc_pkg::ST_IDLE);
               end
            end
         end
         bsmc_pkg::OP_UPDATE: begin
            mdl_run_seen = cur_run;
            if (it.tmo) begin
               mdl_err = 1'b1;
               take_event(bsmc_pkg::EV_ERROR, w);
            end else if (mdl_state == bsmc_pkg::ST_GRINDING) begin
               if (int'(w) - int'(mdl_start_w) >= int'(cfg_target))
                  take_event(bsmc_pkg::EV_TARGET, w);
            end else if (mdl_state == bsmc_pkg::ST_PULL_SHOT) begin
               if (int'(w) > int'(cfg_eps)) take_event(bsmc_pkg::EV_MOVED, w);
            end else if (mdl_state == bsmc_pkg::ST_PULLING) begin
               gap = int'(w) - int'(mdl_ref_w);
               if (gap < 0) gap = -gap;
               if (!mdl_armed || gap > int'(cfg_eps)) begin
                  mdl_armed = 1'b1;
                  mdl_ref_w = w;
                  mdl_steady = it.ms;
               end else if (it.ms - mdl_steady >= 32'(cfg_stime))
                  take_event(bsmc_pkg::EV_STABLE, w);
            end
         end
         default: ;
      endcase
      r.state_now = mdl_state;
      r.mode_now = mdl_mode;
      r.motor_start = pulse_on;
      r.motor_stop = pulse_off;
      r.motor_on = mdl_run_seen;
      r.error_flag = mdl_err;
      return r;
   endfunction

   // mostly transfers that push the current state forward, the rest noise
   function automatic scale_item_type pick_item();
      scale_item_type it;
      int             roll, eps_i;
      eps_i = int'(cfg_eps);
      it.op = 2'($urandom_range(0, 3));
      it.ev = 3'($urandom_range(0, 7));
      it.rq = 1'($urandom_range(0, 1));
      it.w = 20'($urandom);
      it.ms = $urandom;
      it.tmo = ($urandom_range(0, 15) == 0);
      it.run = 1'($urandom_range(0, 1));
      it.chk = 1'b0;
      it.want = '0;
      if ($urandom_range(0, 99) < 82) begin
         it.tmo = 1'b0;
         stamp_ms += $urandom_range(0, int'(cfg_stime) / 3 + 2);
         it.ms = stamp_ms;
         roll = $urandom_range(0, 99);
         it.op = bsmc_pkg::OP_UPDATE;
         case (mdl_state)
            bsmc_pkg::ST_IDLE: begin
               if (roll < 65) begin
                  it.op = bsmc_pkg::OP_EVENT;
                  it.ev = roll[0] ? bsmc_pkg::EV_CUP : bsmc_pkg::EV_START;
                  it.w = 20'(int'($urandom_range(0, 4000)) - 2000);
               end else if (roll < 85) begin
                  it.op = bsmc_pkg::OP_MODE;
                  it.rq = bsmc_pkg::MODE_BREW;
               end
            end
            bsmc_pkg::ST_GRINDING: begin
               it.tmo = ($urandom_range(0, 29) == 0);
               if (roll < 45)
                  it.w = 20'(int'(mdl_start_w) + int'(cfg_target)
                             + int'($urandom_range(0, 40)) - 20);
               else if (roll < 88)
                  it.w = 20'(int'(mdl_start_w) + int'($urandom_range(0, int'(cfg_target))));
               else begin
                  it.op = bsmc_pkg::OP_EVENT;
                  it.ev = roll[0] ? bsmc_pkg::EV_STOP : bsmc_pkg::EV_TARGET;
               end
            end
            bsmc_pkg::ST_ESP_IDLE: begin
               if (roll < 70) begin
                  it.op = bsmc_pkg::OP_EVENT;
                  it.ev = bsmc_pkg::EV_START;
               end else if (roll < 85) begin
                  it.op = bsmc_pkg::OP_MODE;
                  it.rq = bsmc_pkg::MODE_MILL;
               end
            end
            bsmc_pkg::ST_PULL_SHOT: begin
               if (roll < 80)
                  it.w = 20'(int'($urandom_range(0, 2 * eps_i + 10)) - 5);
               else begin
                  it.op = bsmc_pkg::OP_EVENT;
                  it.ev = (roll < 90) ? bsmc_pkg::EV_MOVED : bsmc_pkg::EV_STOP;
               end
            end
            bsmc_pkg::ST_PULLING: begin
               if (roll < 45)
                  it.w = 20'(int'(mdl_ref_w) + int'($urandom_range(0, 2 * eps_i)) - eps_i);
               else if (roll < 88)
                  it.w = 20'(int'(mdl_ref_w) + int'($urandom_range(0, 2 * eps_i + 10))
                             - eps_i - 5);
               else begin
                  it.op = bsmc_pkg::OP_EVENT;
                  it.ev = roll[0] ? bsmc_pkg::EV_STABLE : bsmc_pkg::EV_STOP;
               end
            end
            bsmc_pkg::ST_COMPLETE: begin
               if (roll < 70) begin
                  it.op = bsmc_pkg::OP_EVENT;
                  it.ev = bsmc_pkg::EV_STOP;
               end
            end
            default: begin
               if (roll < 70) begin
                  it.op = bsmc_pkg::OP_EVENT;
                  it.ev = bsmc_pkg::EV_ESTOP;
               end else
                  it.tmo = roll[0];
            end
         endcase
      end
      // an error or emergency stop in espresso mode locks the mode for good
      if (!trap_ok && mdl_mode == bsmc_pkg::MODE_BREW) begin
         it.tmo = 1'b0;
         if (it.op == bsmc_pkg::OP_EVENT &&
             (it.ev == bsmc_pkg::EV_ESTOP || it.ev == bsmc_pkg::EV_ERROR))
            it.ev = bsmc_pkg::EV_STOP;
      end
      return it;
   endfunction

   function automatic void check_field(string name, int want_v, int got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      bsmc_pkg::rsp_type got, exp;
      scale_item_type    it;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (status_q.size() == 0) begin
            $error("rsp transfer with nothing expected: %h", rsp_tdata);
            fails++;
         end else begin
            exp = status_q.pop_front();
            check_field("state_now", exp.state_now, got.state_now);
            check_field("mode_now", exp.mode_now, got.mode_now);
            check_field("motor_start", exp.motor_start, got.motor_start);
            check_field("motor_stop", exp.motor_stop, got.motor_stop);
            check_field("motor_on", exp.motor_on, got.motor_on);
            check_field("error_flag", exp.error_flag, got.error_flag);
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         it = '0;
         it.op = req_tuser;
         {it.run, it.tmo, it.ms, it.w, it.rq, it.ev} = req_tdata[57:0];
         exp = predict_status(it);
         status_q.push_back(typed_on ? typed_want : exp);
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_ask > 0) begin
         hold_left = hold_ask - 1;
         hold_ask = 0;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   task automatic send_item(scale_item_type it);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      typed_on = it.chk;
      typed_want = it.want;
      req_tuser <= it.op;
      req_tdata <= {6'd0, it.run, it.tmo, it.ms, it.w, it.rq, it.ev};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [bsmc_pkg::CSR_DATA_BITS-1:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         bsmc_pkg::REG_TARGET_WEIGHT:  cfg_target = val[bsmc_pkg::TARGET_BITS-1:0];
         bsmc_pkg::REG_STABLE_TIME_MS: cfg_stime = val[bsmc_pkg::STIME_BITS-1:0];
         bsmc_pkg::REG_STABLE_EPSILON: cfg_eps = val[bsmc_pkg::EPS_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      scale_item_type it;
      int             ph, n;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle = 36;
      recv_idle = 59;
      for (n = 0; n < N_HEAD; n++) send_item(plan[n]);
      for (ph = 0; ph < 3; ph++) begin
         drain();
         case (ph)
            0: begin
               csr_write(bsmc_pkg::REG_TARGET_WEIGHT, 32'd0);
               csr_write(bsmc_pkg::REG_STABLE_TIME_MS, 32'd0);
               csr_write(bsmc_pkg::REG_STABLE_EPSILON, 32'd0);
            end
            1: begin
               send_idle = 59;
               recv_idle = 36;
               csr_write(bsmc_pkg::REG_TARGET_WEIGHT, 32'd200000);
               csr_write(bsmc_pkg::REG_STABLE_TIME_MS, 32'd65535);
               csr_write(bsmc_pkg::REG_STABLE_EPSILON, 32'd1000);
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
               csr_write(bsmc_pkg::REG_TARGET_WEIGHT, $urandom_range(100, 3000));
               csr_write(bsmc_pkg::REG_STABLE_TIME_MS, $urandom_range(1, 3000));
               csr_write(bsmc_pkg::REG_STABLE_EPSILON, $urandom_range(1, 60));
            end
         endcase
         for (n = 0; n < N_RAND; n++) begin
            if (ph == 0 && n == 260) drain();
            if (ph == 1 && n == 150) hold_ask = 48;
            trap_ok = (ph == 2 && n >= 470);
            it = pick_item();
            send_item(it);
         end
      end
      for (n = N_HEAD; n < N_PLAN; n++) send_item(plan[n]);
      drain();
      repeat (8) @(posedge clock);
      if (fails == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
